// ----- rtl/core/wdlr_pkg.sv -----
// ----------------------------------------------------------------------------
// wdlr_pkg: shared types and constants of the wrapping DDA line rasterizer
// Default sizes, item command codes, divider operand selects and the
// command / status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package wdlr_pkg;

  localparam int unsigned COORD_BITS_DEF = 12;
  localparam int unsigned FRAC_BITS_DEF  = 16;

  // input item command
  typedef enum logic {
    CMD_START = 1'b0,
    CMD_STEP  = 1'b1
  } cmd_e;

  // divider operand set
  typedef enum logic [1:0] {
    DIV_SEL_X   = 2'd0,
    DIV_SEL_Y   = 2'd1,
    DIV_SEL_MOD = 2'd2
  } div_sel_e;

  // controller -> datapath
  typedef struct packed {
    logic     load_pts;     // latch endpoints, drop any running line
    logic     setup_diff;   // register spans and wrapped span
    logic     setup_pick;   // register chosen span magnitudes and signs
    logic     setup_steps;  // register step count
    logic     div_start;    // launch divider
    div_sel_e div_sel;      // divider operands
    logic     cap_inc_x;    // take x increment from divider
    logic     cap_inc_y;    // take y increment from divider
    logic     cap_line;     // take column modulo, load line state
    logic     step;         // emit pixel and advance
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic steps_zero;   // chosen spans are both zero
    logic div_done;     // divider result ready
    logic line_active;  // pixels remain on the current line
  } dp_sts_t;

endpackage

// ----- rtl/core/wdlr_intf.sv -----
// ----------------------------------------------------------------------------
// wdlr_intf: item channels of the wrapping DDA line rasterizer
// Command channel (start / step items) and pixel result channel, both
// valid/ready; an item moves on a clock edge with valid and ready high.
// ----------------------------------------------------------------------------
interface wdlr_line_if #(
  parameter int unsigned COORD_BITS = wdlr_pkg::COORD_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic                  cmd;
  logic [COORD_BITS-1:0] start_x;
  logic [COORD_BITS-1:0] start_y;
  logic [COORD_BITS-1:0] end_x;
  logic [COORD_BITS-1:0] end_y;

  modport source (output valid, cmd, start_x, start_y, end_x, end_y, input ready);
  modport sink   (input valid, cmd, start_x, start_y, end_x, end_y, output ready);
endinterface

interface wdlr_pix_if #(
  parameter int unsigned COORD_BITS = wdlr_pkg::COORD_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] pixel_x;
  logic [COORD_BITS-1:0] pixel_y;
  logic                  last_pixel;

  modport source (output valid, pixel_x, pixel_y, last_pixel, input ready);
  modport sink   (input valid, pixel_x, pixel_y, last_pixel, output ready);
endinterface

// ----- rtl/core/wdlr_div.sv -----
// ----------------------------------------------------------------------------
// wdlr_div: bit-serial restoring divider
// One quotient bit per cycle. The numerator bits are shifted in MSB first
// from a left-aligned register that collects the quotient at its low end.
// ----------------------------------------------------------------------------
module wdlr_div #(
  parameter  int unsigned DEN_BITS = wdlr_pkg::COORD_BITS_DEF + 1,
  parameter  int unsigned NUM_BITS = wdlr_pkg::FRAC_BITS_DEF + 1,
  localparam int unsigned CNT_BITS = $clog2(NUM_BITS + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [DEN_BITS-1:0] rem_init_i,
  input  logic [NUM_BITS-1:0] num_init_i,
  input  logic [DEN_BITS-1:0] den_i,
  input  logic [CNT_BITS-1:0] iters_i,
  output logic                done_o,
  output logic [NUM_BITS-1:0] quo_o,
  output logic [DEN_BITS-1:0] rem_o
);

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [CNT_BITS-1:0] cnt_q, cnt_d;
  logic [DEN_BITS-1:0] rem_q, rem_d;
  logic [NUM_BITS-1:0] num_q, num_d;
  logic [DEN_BITS-1:0] den_q;
  logic [DEN_BITS:0]   trial;
  logic [DEN_BITS:0]   diff;
  logic                fits;

  // one restoring step
  always_comb begin
    trial = {rem_q, num_q[NUM_BITS-1]};
    diff  = trial - {1'b0, den_q};
    fits  = (trial >= {1'b0, den_q});
    rem_d = fits ? diff[DEN_BITS-1:0] : trial[DEN_BITS-1:0];
    num_d = {num_q[NUM_BITS-2:0], fits};
  end

  // iteration control
  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = iters_i;
    end else if (busy_q) begin
      cnt_d = cnt_q - CNT_BITS'(1);
      if (cnt_q == CNT_BITS'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // operand and result registers
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= rem_init_i;
      num_q <= num_init_i;
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      num_q <= num_d;
    end
  end

  assign done_o = done_q;
  assign quo_o  = num_q;
  assign rem_o  = rem_q;

endmodule

// ----- rtl/core/wdlr_dp.sv -----
// ----------------------------------------------------------------------------
// wdlr_dp: datapath of the wrapping DDA line rasterizer
// Width register, line setup (wrap choice, step count), shared divider for
// the increments and the start column modulo, and the per-step point update
// with an incrementally kept column modulo.
// ----------------------------------------------------------------------------
module wdlr_dp #(
  parameter int unsigned COORD_BITS = wdlr_pkg::COORD_BITS_DEF,
  parameter int unsigned FRAC_BITS  = wdlr_pkg::FRAC_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [COORD_BITS:0]   cfg_data_i,
  input  logic [COORD_BITS-1:0] start_x_i,
  input  logic [COORD_BITS-1:0] start_y_i,
  input  logic [COORD_BITS-1:0] end_x_i,
  input  logic [COORD_BITS-1:0] end_y_i,
  input  wdlr_pkg::dp_cmd_t     cmd_i,
  output wdlr_pkg::dp_sts_t     sts_o,
  output logic [COORD_BITS-1:0] pixel_x_o,
  output logic [COORD_BITS-1:0] pixel_y_o,
  output logic                  last_pixel_o
);

  localparam int unsigned W_BITS    = COORD_BITS + 1;
  localparam int unsigned E_BITS    = COORD_BITS + 2;
  localparam int unsigned POS_BITS  = COORD_BITS + FRAC_BITS + 2;
  localparam int unsigned INC_BITS  = FRAC_BITS + 2;
  localparam int unsigned INT_BITS  = COORD_BITS + 2;
  localparam int unsigned DIVN_BITS = COORD_BITS + FRAC_BITS;
  localparam int unsigned NUM_BITS  =
    (COORD_BITS > FRAC_BITS + 1) ? COORD_BITS : FRAC_BITS + 1;
  localparam int unsigned CNT_BITS  = $clog2(NUM_BITS + 1);

  localparam logic [W_BITS-1:0]   W_MAX     = W_BITS'(1) << COORD_BITS;
  localparam logic [W_BITS-1:0]   W_RST     = W_BITS'(1) << (COORD_BITS - 1);
  localparam logic [CNT_BITS-1:0] ITERS_DIV = CNT_BITS'(FRAC_BITS + 1);
  localparam logic [CNT_BITS-1:0] ITERS_MOD = CNT_BITS'(COORD_BITS);

  // rounded column change per step
  localparam logic [2:0] DELTA_P1 = 3'b001;
  localparam logic [2:0] DELTA_P2 = 3'b010;
  localparam logic [2:0] DELTA_M1 = 3'b111;
  localparam logic [2:0] DELTA_M2 = 3'b110;

  // width register (held clamped to 1 .. 2^COORD_BITS)
  logic [W_BITS-1:0] map_w_q;
  logic [W_BITS-1:0] w_clamp;

  always_comb begin
    if (cfg_data_i == '0) begin
      w_clamp = W_BITS'(1);
    end else if (cfg_data_i > W_MAX) begin
      w_clamp = W_MAX;
    end else begin
      w_clamp = cfg_data_i;
    end
  end

  // endpoints
  logic [COORD_BITS-1:0] x1_q, y1_q, x2_q, y2_q;

  // setup stage 1: spans and wrapped span
  logic [E_BITS-1:0] x1_e, x2_e, y1_e, y2_e, w_e;
  logic [E_BITS-1:0] dx_e, dy_e, wdx_e, x0w_e;
  logic [W_BITS-1:0] dx_q, dy_q, wdx_q, x0w_q;

  always_comb begin
    x1_e = {2'b00, x1_q};
    x2_e = {2'b00, x2_q};
    y1_e = {2'b00, y1_q};
    y2_e = {2'b00, y2_q};
    w_e  = {1'b0, map_w_q};
    dx_e = x2_e - x1_e;
    dy_e = y2_e - y1_e;
    if (x1_q <= x2_q) begin
      wdx_e = dx_e - w_e;
      x0w_e = x1_e;
    end else begin
      wdx_e = dx_e + w_e;
      x0w_e = x1_e - w_e;
    end
  end

  // setup stage 2: magnitudes and wrap choice
  logic [W_BITS-1:0]     dx_mag, wdx_mag, dy_mag;
  logic                  pick_w;
  logic [COORD_BITS-1:0] absdx_q, absdy_q;
  logic                  negx_q, negy_q;
  logic [W_BITS-1:0]     x0_q;

  always_comb begin
    dx_mag  = dx_q[COORD_BITS]  ? (~dx_q + W_BITS'(1))  : dx_q;
    wdx_mag = wdx_q[COORD_BITS] ? (~wdx_q + W_BITS'(1)) : wdx_q;
    dy_mag  = dy_q[COORD_BITS]  ? (~dy_q + W_BITS'(1))  : dy_q;
    pick_w  = (wdx_mag <= dx_mag);
  end

  // setup stage 3: step count
  logic [COORD_BITS-1:0] steps_q;
  logic [COORD_BITS-1:0] steps_c;

  assign steps_c = (absdx_q > absdy_q) ? absdx_q : absdy_q;

  // divider operands
  logic [DIVN_BITS-1:0]  div_n;
  logic [COORD_BITS-1:0] div_absd;
  logic [W_BITS-1:0]     div_rem_init;
  logic [NUM_BITS-1:0]   div_num_init;
  logic [W_BITS-1:0]     div_den;
  logic [CNT_BITS-1:0]   div_iters;
  logic                  div_done;
  logic [NUM_BITS-1:0]   div_quo;
  logic [W_BITS-1:0]     div_rem;

  always_comb begin
    div_absd = (cmd_i.div_sel == wdlr_pkg::DIV_SEL_Y) ? absdy_q : absdx_q;
    // |d| * 2^F + steps/2, rounded quotient below 2^(F+1)
    div_n    = (DIVN_BITS'(div_absd) << FRAC_BITS) + DIVN_BITS'(steps_q >> 1);
    unique case (cmd_i.div_sel)
      wdlr_pkg::DIV_SEL_X, wdlr_pkg::DIV_SEL_Y: begin
        div_rem_init = W_BITS'(div_n >> (FRAC_BITS + 1));
        div_num_init = NUM_BITS'(div_n[FRAC_BITS:0]) << (NUM_BITS - FRAC_BITS - 1);
        div_den      = {1'b0, steps_q};
        div_iters    = ITERS_DIV;
      end
      wdlr_pkg::DIV_SEL_MOD: begin
        div_rem_init = '0;
        div_num_init = NUM_BITS'(x1_q) << (NUM_BITS - COORD_BITS);
        div_den      = map_w_q;
        div_iters    = ITERS_MOD;
      end
      default: begin
        div_rem_init = '0;
        div_num_init = '0;
        div_den      = map_w_q;
        div_iters    = ITERS_MOD;
      end
    endcase
  end

  wdlr_div #(
    .DEN_BITS (W_BITS),
    .NUM_BITS (NUM_BITS)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .rem_init_i (div_rem_init),
    .num_init_i (div_num_init),
    .den_i      (div_den),
    .iters_i    (div_iters),
    .done_o     (div_done),
    .quo_o      (div_quo),
    .rem_o      (div_rem)
  );

  // signed increment from quotient
  logic [INC_BITS-1:0] quo_e;
  logic [INC_BITS-1:0] inc_x_q, inc_y_q;

  assign quo_e = {1'b0, div_quo[FRAC_BITS:0]};

  // line state: points held with a half-pixel bias, so rounding is a select
  logic [POS_BITS-1:0]   bx_q, by_q, bx_d, by_d;
  logic [COORD_BITS-1:0] m_q, m_d;
  logic [COORD_BITS-1:0] steps_left_q;

  assign bx_d = bx_q + {{(POS_BITS - INC_BITS){inc_x_q[INC_BITS-1]}}, inc_x_q};
  assign by_d = by_q + {{(POS_BITS - INC_BITS){inc_y_q[INC_BITS-1]}}, inc_y_q};

  // rounding: floor of the biased value, minus one on a negative exact half
  logic [INT_BITS-1:0]   int_x_old, int_x_new, int_y;
  logic                  corr_x_old, corr_x_new, corr_y;
  logic [2:0]            delta;
  logic [COORD_BITS-1:0] py_c;

  always_comb begin
    int_x_old  = bx_q[POS_BITS-1:FRAC_BITS];
    int_x_new  = bx_d[POS_BITS-1:FRAC_BITS];
    int_y      = by_q[POS_BITS-1:FRAC_BITS];
    corr_x_old = (bx_q[FRAC_BITS-1:0] == '0) && (bx_q[POS_BITS-1] || (int_x_old == '0));
    corr_x_new = (bx_d[FRAC_BITS-1:0] == '0) && (bx_d[POS_BITS-1] || (int_x_new == '0));
    corr_y     = (by_q[FRAC_BITS-1:0] == '0) && (by_q[POS_BITS-1] || (int_y == '0));
    delta      = int_x_new[2:0] - int_x_old[2:0] - {2'b00, corr_x_new} + {2'b00, corr_x_old};
    py_c       = int_y[COORD_BITS-1:0] - COORD_BITS'(corr_y);
  end

  // column modulo candidates for a change of -2 .. +2
  logic [W_BITS-1:0]     m_e, m_inc1, m_inc2, m_inc2w, m_wm1, m_wm2;
  logic [COORD_BITS-1:0] m_p1, m_p2, m_m1, m_m2;
  logic                  w_is_one;

  always_comb begin
    w_is_one = (map_w_q == W_BITS'(1));
    m_e      = {1'b0, m_q};
    m_inc1   = m_e + W_BITS'(1);
    m_inc2   = m_e + W_BITS'(2);
    m_inc2w  = m_inc2 - map_w_q;
    m_wm1    = map_w_q - W_BITS'(1);
    m_wm2    = m_e + map_w_q - W_BITS'(2);
    m_p1     = (m_inc1 == map_w_q) ? '0 : m_inc1[COORD_BITS-1:0];
    if (w_is_one) begin
      m_p2 = '0;
    end else if (m_inc2 >= map_w_q) begin
      m_p2 = m_inc2w[COORD_BITS-1:0];
    end else begin
      m_p2 = m_inc2[COORD_BITS-1:0];
    end
    m_m1 = (m_q == '0) ? m_wm1[COORD_BITS-1:0] : m_q - COORD_BITS'(1);
    if (w_is_one) begin
      m_m2 = '0;
    end else if (m_q >= COORD_BITS'(2)) begin
      m_m2 = m_q - COORD_BITS'(2);
    end else begin
      m_m2 = m_wm2[COORD_BITS-1:0];
    end
    case (delta)
      DELTA_P1: m_d = m_p1;
      DELTA_P2: m_d = m_p2;
      DELTA_M1: m_d = m_m1;
      DELTA_M2: m_d = m_m2;
      default:  m_d = m_q;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_w_q      <= W_RST;
      steps_left_q <= '0;
    end else begin
      if (cfg_we_i) begin
        map_w_q <= w_clamp;
      end
      if (cmd_i.load_pts) begin
        steps_left_q <= '0;
      end else if (cmd_i.cap_line) begin
        steps_left_q <= steps_q;
      end else if (cmd_i.step) begin
        steps_left_q <= steps_left_q - COORD_BITS'(1);
      end
    end
  end

  // payload registers
  logic [COORD_BITS-1:0] px_q, py_q;
  logic                  last_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_pts) begin
      x1_q <= start_x_i;
      y1_q <= start_y_i;
      x2_q <= end_x_i;
      y2_q <= end_y_i;
    end
    if (cmd_i.setup_diff) begin
      dx_q  <= dx_e[W_BITS-1:0];
      dy_q  <= dy_e[W_BITS-1:0];
      wdx_q <= wdx_e[W_BITS-1:0];
      x0w_q <= x0w_e[W_BITS-1:0];
    end
    if (cmd_i.setup_pick) begin
      absdx_q <= pick_w ? wdx_mag[COORD_BITS-1:0] : dx_mag[COORD_BITS-1:0];
      negx_q  <= pick_w ? wdx_q[COORD_BITS] : dx_q[COORD_BITS];
      x0_q    <= pick_w ? x0w_q : {1'b0, x1_q};
      absdy_q <= dy_mag[COORD_BITS-1:0];
      negy_q  <= dy_q[COORD_BITS];
    end
    if (cmd_i.setup_steps) begin
      steps_q <= steps_c;
    end
    if (cmd_i.cap_inc_x) begin
      inc_x_q <= negx_q ? (~quo_e + INC_BITS'(1)) : quo_e;
    end
    if (cmd_i.cap_inc_y) begin
      inc_y_q <= negy_q ? (~quo_e + INC_BITS'(1)) : quo_e;
    end
    if (cmd_i.cap_line) begin
      m_q  <= div_rem[COORD_BITS-1:0];
      bx_q <= {x0_q[COORD_BITS], x0_q, 1'b1, {(FRAC_BITS - 1){1'b0}}};
      by_q <= {2'b00, y1_q, 1'b1, {(FRAC_BITS - 1){1'b0}}};
    end else if (cmd_i.step) begin
      m_q  <= m_d;
      bx_q <= bx_d;
      by_q <= by_d;
    end
    if (cmd_i.step) begin
      px_q   <= m_q;
      py_q   <= py_c;
      last_q <= (steps_left_q == COORD_BITS'(1));
    end
  end

  // status
  assign sts_o.steps_zero  = (absdx_q == '0) && (absdy_q == '0);
  assign sts_o.div_done    = div_done;
  assign sts_o.line_active = (steps_left_q != '0);

  assign pixel_x_o    = px_q;
  assign pixel_y_o    = py_q;
  assign last_pixel_o = last_q;

endmodule

// ----- rtl/core/wdlr_ctrl.sv -----
// ----------------------------------------------------------------------------
// wdlr_ctrl: controller of the wrapping DDA line rasterizer
// Input handshake, output valid register, and the start sequence: setup of
// spans, wrap choice and step count, then x increment, y increment and start
// column modulo on the shared divider (skipped for a zero-length line).
// ----------------------------------------------------------------------------
module wdlr_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_cmd_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output wdlr_pkg::dp_cmd_t dp_cmd_o,
  input  wdlr_pkg::dp_sts_t dp_sts_i
);

  typedef enum logic [9:0] {
    ST_IDLE  = 10'b00_0000_0001,
    ST_DIFF  = 10'b00_0000_0010,
    ST_PICK  = 10'b00_0000_0100,
    ST_STEPS = 10'b00_0000_1000,
    ST_XGO   = 10'b00_0001_0000,
    ST_XRUN  = 10'b00_0010_0000,
    ST_YGO   = 10'b00_0100_0000,
    ST_YRUN  = 10'b00_1000_0000,
    ST_MGO   = 10'b01_0000_0000,
    ST_MRUN  = 10'b10_0000_0000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;

  // take items only when idle and the output register can take a pixel
  assign in_ready_o = (state_q == ST_IDLE) && (!out_valid_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;

  // sequencer
  always_comb begin
    state_d          = state_q;
    dp_cmd_o         = '0;
    dp_cmd_o.div_sel = wdlr_pkg::DIV_SEL_X;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (wdlr_pkg::cmd_e'(in_cmd_i) == wdlr_pkg::CMD_START) begin
            dp_cmd_o.load_pts = 1'b1;
            state_d           = ST_DIFF;
          end else if (dp_sts_i.line_active) begin
            dp_cmd_o.step = 1'b1;
          end
        end
      end
      ST_DIFF: begin
        dp_cmd_o.setup_diff = 1'b1;
        state_d             = ST_PICK;
      end
      ST_PICK: begin
        dp_cmd_o.setup_pick = 1'b1;
        state_d             = ST_STEPS;
      end
      ST_STEPS: begin
        dp_cmd_o.setup_steps = 1'b1;
        // zero-length line: nothing to draw
        state_d = dp_sts_i.steps_zero ? ST_IDLE : ST_XGO;
      end
      ST_XGO: begin
        dp_cmd_o.div_start = 1'b1;
        dp_cmd_o.div_sel   = wdlr_pkg::DIV_SEL_X;
        state_d            = ST_XRUN;
      end
      ST_XRUN: begin
        if (dp_sts_i.div_done) begin
          dp_cmd_o.cap_inc_x = 1'b1;
          state_d            = ST_YGO;
        end
      end
      ST_YGO: begin
        dp_cmd_o.div_start = 1'b1;
        dp_cmd_o.div_sel   = wdlr_pkg::DIV_SEL_Y;
        state_d            = ST_YRUN;
      end
      ST_YRUN: begin
        if (dp_sts_i.div_done) begin
          dp_cmd_o.cap_inc_y = 1'b1;
          state_d            = ST_MGO;
        end
      end
      ST_MGO: begin
        dp_cmd_o.div_start = 1'b1;
        dp_cmd_o.div_sel   = wdlr_pkg::DIV_SEL_MOD;
        state_d            = ST_MRUN;
      end
      ST_MRUN: begin
        if (dp_sts_i.div_done) begin
          dp_cmd_o.cap_line = 1'b1;
          state_d           = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // output valid: set on a pixel, cleared when taken
  assign out_valid_d = dp_cmd_o.step || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ----- rtl/core/wrapping_dda_line_rasterizer.sv -----
// ----------------------------------------------------------------------------
// wrapping_dda_line_rasterizer: DDA line drawing on a horizontally wrapping map
// Step item: pixel valid the cycle after acceptance on an active line; one step
//   item per cycle while pixels are taken. Start item: input held through line
//   setup and the bit-serial divider runs for both increments and column modulo.
// Reset: no line active, map width 2^(COORD_BITS-1), output register empty.
// ----------------------------------------------------------------------------
module wrapping_dda_line_rasterizer #(
  parameter int unsigned COORD_BITS = wdlr_pkg::COORD_BITS_DEF,
  parameter int unsigned FRAC_BITS  = wdlr_pkg::FRAC_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [COORD_BITS:0] cfg_data_i,
  wdlr_line_if.sink           line_i,
  wdlr_pix_if.source          pix_o
);

  wdlr_pkg::dp_cmd_t dp_cmd;
  wdlr_pkg::dp_sts_t dp_sts;

  // sequencing and handshakes
  wdlr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (line_i.valid),
    .in_cmd_i    (line_i.cmd),
    .in_ready_o  (line_i.ready),
    .out_valid_o (pix_o.valid),
    .out_ready_i (pix_o.ready),
    .dp_cmd_o    (dp_cmd),
    .dp_sts_i    (dp_sts)
  );

  // arithmetic and line state
  wdlr_dp #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_data_i   (cfg_data_i),
    .start_x_i    (line_i.start_x),
    .start_y_i    (line_i.start_y),
    .end_x_i      (line_i.end_x),
    .end_y_i      (line_i.end_y),
    .cmd_i        (dp_cmd),
    .sts_o        (dp_sts),
    .pixel_x_o    (pix_o.pixel_x),
    .pixel_y_o    (pix_o.pixel_y),
    .last_pixel_o (pix_o.last_pixel)
  );

endmodule
